FILE: rtl/dllm_pkg.sv
// Shared types and constants for the doubly linked list manager.
// Holds operation and status codes and the controller/datapath interface structs.
// No dependencies.
`default_nettype none

package dllm_pkg;

  // Fixed widths of the stream fields.
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned TDATA_W  = 40;
  localparam int unsigned PAD_W    = TDATA_W - VALUE_W - COUNT_W;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INS_FRONT = 2'd0,
    FUNC_INS_END   = 2'd1,
    FUNC_DELETE    = 2'd2,
    FUNC_LIST      = 2'd3
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE   = 3'd0,
    ST_FULL   = 3'd1,
    ST_EMPTY  = 3'd2,
    ST_BADPOS = 3'd3,
    ST_ITEM   = 3'd4
  } status_e;

  // Source of the node address read from the link and value memories.
  typedef enum logic [1:0] {
    ADDR_CUR    = 2'd0,
    ADDR_HEAD   = 2'd1,
    ADDR_FOLLOW = 2'd2
  } addr_sel_e;

  typedef struct packed {
    logic      load;        // capture the accepted transaction
    logic      insert;      // link a new node
    logic      unlink;      // remove the node under the walk pointer
    logic      step;        // decrement the walk counter
    logic      emit_item;   // load a listed element into the output register
    logic      emit_status; // load a status result into the output register
    status_e   code;
    addr_sel_e addr_sel;
  } dllm_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic full;
    logic pos_bad;
    logic steps_zero;
    logic out_free;
  } dllm_stat_t;

endpackage

`default_nettype wire

FILE: rtl/dllm_ram.sv
// Generic single-write, single-read memory with a registered read port.
// No dependencies.
`default_nettype none

module dllm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: rtl/dllm_ctrl.sv
// Controller state machine of the doubly linked list manager.
// Sequences insert, delete walk, listing and status results; depends on dllm_pkg.
`default_nettype none

module dllm_ctrl
  import dllm_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire func_e      func_i,
  input  wire dllm_stat_t stat_i,
  output dllm_cmd_t       cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_DEL,
    S_LIST,
    S_EMIT
  } state_e;

  state_e  state_q, state_d;
  status_e code_q, code_d;

  always_comb begin
    cmd_o          = '0;
    cmd_o.code     = code_q;
    cmd_o.addr_sel = ADDR_CUR;
    state_d        = state_q;
    code_d         = code_q;
    in_ready_o     = (state_q == S_IDLE);

    unique case (state_q)
      S_IDLE: begin
        // The head node is read every idle cycle so a walk can start at once.
        cmd_o.addr_sel = ADDR_HEAD;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          unique case (func_i) inside
            FUNC_INS_FRONT, FUNC_INS_END: begin
              if (stat_i.full) begin
                code_d  = ST_FULL;
                state_d = S_EMIT;
              end else begin
                state_d = S_INS;
              end
            end
            FUNC_DELETE: begin
              if (stat_i.cnt_zero) begin
                code_d  = ST_EMPTY;
                state_d = S_EMIT;
              end else if (stat_i.pos_bad) begin
                code_d  = ST_BADPOS;
                state_d = S_EMIT;
              end else begin
                state_d = S_DEL;
              end
            end
            FUNC_LIST: begin
              if (stat_i.cnt_zero) begin
                code_d  = ST_EMPTY;
                state_d = S_EMIT;
              end else begin
                state_d = S_LIST;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_INS: begin
        cmd_o.insert = 1'b1;
        code_d       = ST_DONE;
        state_d      = S_EMIT;
      end
      S_DEL: begin
        if (stat_i.steps_zero) begin
          cmd_o.unlink = 1'b1;
          code_d       = ST_DONE;
          state_d      = S_EMIT;
        end else begin
          cmd_o.step     = 1'b1;
          cmd_o.addr_sel = ADDR_FOLLOW;
        end
      end
      S_LIST: begin
        if (stat_i.out_free) begin
          cmd_o.emit_item = 1'b1;
          if (stat_i.steps_zero) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.step     = 1'b1;
            cmd_o.addr_sel = ADDR_FOLLOW;
          end
        end
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit_status = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      code_q  <= ST_DONE;
    end else begin
      state_q <= state_d;
      code_q  <= code_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/dllm_dp.sv
// Datapath of the doubly linked list manager: node pool memories, free list,
// head/tail/count registers, walk pointer and output register; depends on dllm_pkg, dllm_ram.
`default_nettype none

module dllm_dp
  import dllm_pkg::*;
#(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned VALUE_BITS = 32
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire dllm_cmd_t                  cmd_i,
  output dllm_stat_t                      stat_o,
  input  wire func_e                      func_i,
  input  wire logic signed [VALUE_W-1:0]  value_i,
  input  wire logic        [POS_W-1:0]    position_i,
  output logic                            m_valid_o,
  input  wire logic                       m_ready_i,
  output logic             [STATUS_W-1:0] m_status_o,
  output logic signed      [VALUE_W-1:0]  m_data_o,
  output logic                            m_last_o,
  output logic             [COUNT_W-1:0]  m_count_o
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic [IW-1:0] head_q, head_d, tail_q, tail_d, cur_q;
  logic [CW-1:0] cnt_q, cnt_d, sp_q, sp_d, fresh_q, fresh_d, steps_q;
  func_e         func_q;
  logic [VALUE_BITS-1:0] value_q;

  logic                    out_valid_q;
  logic [STATUS_W-1:0]     out_status_q;
  logic signed [VALUE_W-1:0] out_data_q;
  logic                    out_last_q;
  logic [COUNT_W-1:0]      out_count_q;

  logic [IW-1:0] raddr, new_node, next_rdata, prev_rdata, stack_rdata;
  logic [VALUE_BITS-1:0] val_rdata;

  logic          next_we, prev_we;
  logic [IW-1:0] next_waddr, next_wdata, prev_waddr, prev_wdata;
  logic          front, middle, out_free;

  always_comb begin
    unique case (cmd_i.addr_sel)
      ADDR_HEAD:   raddr = head_q;
      ADDR_FOLLOW: raddr = next_rdata;
      default:     raddr = cur_q;
    endcase
  end

  // Nodes freed by a delete are reused first; untouched nodes are handed out in order.
  assign new_node = (sp_q != '0) ? stack_rdata : fresh_q[IW-1:0];
  assign front    = (func_q == FUNC_INS_FRONT);
  assign middle   = (cnt_q != CW'(1)) && (cur_q != head_q) && (cur_q != tail_q);
  assign out_free = !out_valid_q || m_ready_i;

  // The back link of the head and the forward link of the tail are never read.
  always_comb begin
    next_we    = 1'b0;
    next_waddr = new_node;
    next_wdata = head_q;
    prev_we    = 1'b0;
    prev_waddr = head_q;
    prev_wdata = new_node;
    if (cmd_i.insert && (cnt_q != '0)) begin
      next_we = 1'b1;
      prev_we = 1'b1;
      if (!front) begin
        next_waddr = tail_q;
        next_wdata = new_node;
        prev_waddr = new_node;
        prev_wdata = tail_q;
      end
    end else if (cmd_i.unlink && middle) begin
      next_we    = 1'b1;
      next_waddr = prev_rdata;
      next_wdata = next_rdata;
      prev_we    = 1'b1;
      prev_waddr = next_rdata;
      prev_wdata = prev_rdata;
    end
  end

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    cnt_d   = cnt_q;
    sp_d    = sp_q;
    fresh_d = fresh_q;
    if (cmd_i.insert) begin
      if (cnt_q == '0) begin
        head_d = new_node;
        tail_d = new_node;
      end else if (front) begin
        head_d = new_node;
      end else begin
        tail_d = new_node;
      end
      cnt_d = cnt_q + CW'(1);
      if (sp_q != '0) begin
        sp_d = sp_q - CW'(1);
      end else begin
        fresh_d = fresh_q + CW'(1);
      end
    end else if (cmd_i.unlink) begin
      if (cnt_q == CW'(1)) begin
        head_d = '0;
        tail_d = '0;
      end else if (cur_q == head_q) begin
        head_d = next_rdata;
      end else if (cur_q == tail_q) begin
        tail_d = prev_rdata;
      end
      cnt_d = cnt_q - CW'(1);
      sp_d  = sp_q + CW'(1);
    end
  end

  dllm_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.insert),
    .waddr_i (new_node),
    .wdata_i (value_q),
    .raddr_i (raddr),
    .rdata_o (val_rdata)
  );

  dllm_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (next_we),
    .waddr_i (next_waddr),
    .wdata_i (next_wdata),
    .raddr_i (raddr),
    .rdata_o (next_rdata)
  );

  dllm_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (prev_we),
    .waddr_i (prev_waddr),
    .wdata_i (prev_wdata),
    .raddr_i (raddr),
    .rdata_o (prev_rdata)
  );

  dllm_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.unlink),
    .waddr_i (sp_q[IW-1:0]),
    .wdata_i (cur_q),
    .raddr_i (IW'(sp_q - CW'(1))),
    .rdata_o (stack_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      cur_q       <= '0;
      cnt_q       <= '0;
      sp_q        <= '0;
      fresh_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      cur_q   <= raddr;
      cnt_q   <= cnt_d;
      sp_q    <= sp_d;
      fresh_q <= fresh_d;
      if (cmd_i.emit_item || cmd_i.emit_status) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q  <= func_i;
      value_q <= VALUE_BITS'(value_i);
      if (func_i == FUNC_LIST) begin
        steps_q <= cnt_q - CW'(1);
      end else begin
        steps_q <= CW'(position_i) - CW'(1);
      end
    end else if (cmd_i.step) begin
      steps_q <= steps_q - CW'(1);
    end
    if (cmd_i.emit_item) begin
      out_status_q <= ST_ITEM;
      out_data_q   <= VALUE_W'($signed(val_rdata));
      out_last_q   <= (steps_q == '0);
      out_count_q  <= COUNT_W'(cnt_q);
    end else if (cmd_i.emit_status) begin
      out_status_q <= cmd_i.code;
      out_data_q   <= '0;
      out_last_q   <= 1'b1;
      out_count_q  <= COUNT_W'(cnt_q);
    end
  end

  assign stat_o.cnt_zero   = (cnt_q == '0);
  assign stat_o.full       = (cnt_q == CW'(CAPACITY));
  assign stat_o.pos_bad    = (position_i == '0) || (32'(position_i) > 32'(cnt_q));
  assign stat_o.steps_zero = (steps_q == '0);
  assign stat_o.out_free   = out_free;

  assign m_valid_o  = out_valid_q;
  assign m_status_o = out_status_q;
  assign m_data_o   = out_data_q;
  assign m_last_o   = out_last_q;
  assign m_count_o  = out_count_q;

endmodule

`default_nettype wire

FILE: rtl/doubly_linked_list_manager_core.sv
// Doubly linked list manager: bounded list in a node pool with insert, delete and listing.
// Insert: the node is linked, then the status result follows. Delete at position p: the
// walk through the forward-link memory takes one node per cycle, then unlinks the node.
// Listing n nodes: one result per cycle unless the output stalls. The next item is
// accepted once the last result of the current one is in the output register.
// Reset is asynchronous and immediate: the list is empty, no memory clearing pass.
`default_nettype none

module doubly_linked_list_manager_core
  import dllm_pkg::*;
#(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned VALUE_BITS = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [TDATA_W-1:0] s_axis_tdata,  // value[31:0], position[36:32], zero
  input  wire logic [FUNC_W-1:0]  s_axis_tuser,  // func[1:0]
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic [TDATA_W-1:0]      m_axis_tdata,  // data[31:0], count[36:32], zero
  output logic [STATUS_W-1:0]     m_axis_tuser,  // status[2:0]
  output logic                    m_axis_tlast
);

  dllm_cmd_t  cmd;
  dllm_stat_t stat;
  func_e      func;

  logic signed [VALUE_W-1:0] out_data;
  logic [COUNT_W-1:0]        out_count;

  assign func = func_e'(s_axis_tuser);

  dllm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .func_i     (func),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  dllm_dp #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .func_i     (func),
    .value_i    ($signed(s_axis_tdata[VALUE_W-1:0])),
    .position_i (s_axis_tdata[VALUE_W+POS_W-1:VALUE_W]),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_status_o (m_axis_tuser),
    .m_data_o   (out_data),
    .m_last_o   (m_axis_tlast),
    .m_count_o  (out_count)
  );

  assign m_axis_tdata = {{PAD_W{1'b0}}, out_count, out_data};

endmodule

`default_nettype wire
